// ===== design/sorted_interval_set_macros.svh =====
// assertion macros used by the interval set top module
`ifndef SORTED_INTERVAL_SET_MACROS_SVH
`define SORTED_INTERVAL_SET_MACROS_SVH

// clocked check, idle during reset
`define SIS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// clocked implication, idle during reset
`define SIS_IMPLY(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (prop)) \
        else $error(msg);

`endif

// ===== design/sis_pkg.sv =====
// types and constants of the interval set
`default_nettype none
package sis_pkg;
    localparam int MAX_RANGES = 64;
    localparam int IDX_W      = $clog2(MAX_RANGES);
    localparam int CNT_W      = $clog2(MAX_RANGES + 1);
    localparam int VAL_W      = 32;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_QUERY  = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_WR1,
        S_WR2,
        S_RESP
    } t_state;

    typedef struct packed {
        logic [VAL_W-1:0] lo;
        logic [VAL_W-1:0] hi;
    } t_range;

    typedef struct packed {
        logic             found_k;
        logic [IDX_W-1:0] k_idx;
        t_range           k_rng;
        logic             found_l;
        logic [IDX_W-1:0] l_idx;
        logic [VAL_W-1:0] l_lo;
        logic             found_r;
        logic [IDX_W-1:0] r_idx;
        logic [VAL_W-1:0] r_hi;
        t_range           last;
    } t_scan_res;
endpackage
`default_nettype wire

// ===== design/sis_ram.sv =====
// generic single write port ram with registered read
`default_nettype none
module sis_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end
endmodule
`default_nettype wire

// ===== design/sis_scan.sv =====
// compares each range read from the table against the lookup value
`default_nettype none
module sis_scan import sis_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_clear,
    input  wire logic             i_rd_valid,
    input  wire logic [IDX_W-1:0] i_rd_idx,
    input  wire t_range           i_rd_data,
    input  wire logic [VAL_W-1:0] i_value,
    output t_scan_res             o_res
);
    t_scan_res r_res;
    t_scan_res n_res;
    logic      hit_k;
    logic      hit_l;
    logic      hit_r;

    always_comb begin
        hit_k = (i_rd_data.lo <= i_value) && (i_value <= i_rd_data.hi);
        // neighbor tests never wrap at the ends of the number range
        hit_l = (i_rd_data.hi != '1) && ((i_rd_data.hi + VAL_W'(1)) == i_value);
        hit_r = (i_rd_data.lo != '0) && ((i_rd_data.lo - VAL_W'(1)) == i_value);
        n_res = r_res;
        if (i_clear) begin
            n_res.found_k = 1'b0;
            n_res.found_l = 1'b0;
            n_res.found_r = 1'b0;
        end else if (i_rd_valid) begin
            n_res.last = i_rd_data;
            if (hit_k) begin
                n_res.found_k = 1'b1;
                n_res.k_idx   = i_rd_idx;
                n_res.k_rng   = i_rd_data;
            end
            if (hit_l) begin
                n_res.found_l = 1'b1;
                n_res.l_idx   = i_rd_idx;
                n_res.l_lo    = i_rd_data.lo;
            end
            if (hit_r) begin
                n_res.found_r = 1'b1;
                n_res.r_idx   = i_rd_idx;
                n_res.r_hi    = i_rd_data.hi;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res <= '0;
        end else begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;
endmodule
`default_nettype wire

// ===== design/sorted_interval_set.sv =====
// sorted_interval_set: set of 32-bit numbers held as disjoint inclusive ranges
// input channel i_valid/o_stall carries a request word: i_req_type (insert,
// remove, query) and i_value. output channel o_valid/i_stall carries one
// result word per request: was_present, table_full and range_count.
// ranges sit unordered in one 64-entry ram (start and end in one word); the
// order of the set is only ever seen through the results.
// each request scans every held range once, one ram read a cycle, then
// writes back at most two entries.
// one request is in flight at a time; o_stall is high while it runs.
// a result waits in the output register while i_stall is high; the block
// holds the finished request until that register is free.
// reset clears the range count and the control state; ram contents are
// never read beyond the count, so the ram needs no clearing pass and the
// block accepts a request as soon as reset is released.
`default_nettype none
`include "sorted_interval_set_macros.svh"
module sorted_interval_set import sis_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_stall,
    input  wire logic [1:0]       i_req_type,
    input  wire logic [VAL_W-1:0] i_value,
    output logic                  o_valid,
    input  wire logic             i_stall,
    output logic                  o_was_present,
    output logic                  o_table_full,
    output logic [CNT_W-1:0]      o_range_count
);
    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_iss;
    logic             r_pend;
    logic [IDX_W-1:0] r_pidx;
    logic [1:0]       r_op;
    logic [VAL_W-1:0] r_val;
    logic [CNT_W-1:0] r_cnt;
    logic             r_full;
    logic             r_w1_en, r_w2_en;
    logic [IDX_W-1:0] r_w1_addr, r_w2_addr;
    t_range           r_w1_data, r_w2_data;
    logic             r_out_valid, r_out_present, r_out_full;
    logic [CNT_W-1:0] r_out_cnt;

    logic             n_w1_en, n_w2_en, n_full;
    logic [IDX_W-1:0] n_w1_addr, n_w2_addr;
    t_range           n_w1_data, n_w2_data;
    logic [CNT_W-1:0] n_cnt;

    logic             accept;
    logic             issue;
    logic             out_free;
    logic             ram_wr_en;
    logic [IDX_W-1:0] ram_wr_addr;
    t_range           ram_wr_data;
    t_range           ram_rd_data;
    t_scan_res        res;
    logic [IDX_W-1:0] last_idx;
    t_range           merged;
    logic             at_max;

    assign accept   = i_valid && !o_stall;
    assign out_free = !r_out_valid || !i_stall;
    assign issue    = (r_state == S_SCAN) && (r_iss < r_cnt);

    assign ram_wr_en   = ((r_state == S_WR1) && r_w1_en) || ((r_state == S_WR2) && r_w2_en);
    assign ram_wr_addr = (r_state == S_WR1) ? r_w1_addr : r_w2_addr;
    assign ram_wr_data = (r_state == S_WR1) ? r_w1_data : r_w2_data;

    sis_ram #(
        .WIDTH($bits(t_range)),
        .DEPTH(MAX_RANGES)
    ) u_ram (
        .i_clk    (i_clk),
        .i_wr_en  (ram_wr_en),
        .i_wr_addr(ram_wr_addr),
        .i_wr_data(ram_wr_data),
        .i_rd_en  (issue),
        .i_rd_addr(r_iss[IDX_W-1:0]),
        .o_rd_data(ram_rd_data)
    );

    sis_scan u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clear   (accept),
        .i_rd_valid(r_pend),
        .i_rd_idx  (r_pidx),
        .i_rd_data (ram_rd_data),
        .i_value   (r_val),
        .o_res     (res)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (accept) n_state = S_SCAN;
            // last read word is folded into the scan result at this edge
            S_SCAN:   if (!issue) n_state = S_DECIDE;
            S_DECIDE: n_state = S_WR1;
            S_WR1:    n_state = S_WR2;
            S_WR2:    n_state = S_RESP;
            S_RESP:   if (out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // write-back plan from the scan result
    always_comb begin
        last_idx  = IDX_W'(r_cnt - CNT_W'(1));
        merged    = '{lo: res.l_lo, hi: res.r_hi};
        at_max    = (r_cnt >= CNT_W'(MAX_RANGES));
        n_w1_en   = 1'b0;
        n_w2_en   = 1'b0;
        n_w1_addr = '0;
        n_w2_addr = '0;
        n_w1_data = '0;
        n_w2_data = '0;
        n_full    = 1'b0;
        n_cnt     = r_cnt;
        if ((r_op == OP_INSERT) && !res.found_k) begin
            priority if (res.found_l && res.found_r) begin
                // bridge: keep the merged range, fill the freed slot from the last
                n_cnt   = r_cnt - CNT_W'(1);
                n_w1_en = 1'b1;
                priority if (res.l_idx == last_idx) begin
                    n_w1_addr = res.r_idx;
                    n_w1_data = merged;
                end else if (res.r_idx == last_idx) begin
                    n_w1_addr = res.l_idx;
                    n_w1_data = merged;
                end else begin
                    n_w1_addr = res.l_idx;
                    n_w1_data = merged;
                    n_w2_en   = 1'b1;
                    n_w2_addr = res.r_idx;
                    n_w2_data = res.last;
                end
            end else if (res.found_l) begin
                n_w1_en   = 1'b1;
                n_w1_addr = res.l_idx;
                n_w1_data = '{lo: res.l_lo, hi: r_val};
            end else if (res.found_r) begin
                n_w1_en   = 1'b1;
                n_w1_addr = res.r_idx;
                n_w1_data = '{lo: r_val, hi: res.r_hi};
            end else if (at_max) begin
                n_full = 1'b1;
            end else begin
                n_w1_en   = 1'b1;
                n_w1_addr = r_cnt[IDX_W-1:0];
                n_w1_data = '{lo: r_val, hi: r_val};
                n_cnt     = r_cnt + CNT_W'(1);
            end
        end else if ((r_op == OP_REMOVE) && res.found_k) begin
            priority if (res.k_rng.lo == res.k_rng.hi) begin
                n_cnt     = r_cnt - CNT_W'(1);
                n_w1_en   = (res.k_idx != last_idx);
                n_w1_addr = res.k_idx;
                n_w1_data = res.last;
            end else if (r_val == res.k_rng.lo) begin
                n_w1_en   = 1'b1;
                n_w1_addr = res.k_idx;
                n_w1_data = '{lo: r_val + VAL_W'(1), hi: res.k_rng.hi};
            end else if (r_val == res.k_rng.hi) begin
                n_w1_en   = 1'b1;
                n_w1_addr = res.k_idx;
                n_w1_data = '{lo: res.k_rng.lo, hi: r_val - VAL_W'(1)};
            end else if (at_max) begin
                n_full = 1'b1;
            end else begin
                // split keeps the lower part in place and appends the upper part
                n_w1_en   = 1'b1;
                n_w1_addr = res.k_idx;
                n_w1_data = '{lo: res.k_rng.lo, hi: r_val - VAL_W'(1)};
                n_w2_en   = 1'b1;
                n_w2_addr = r_cnt[IDX_W-1:0];
                n_w2_data = '{lo: r_val + VAL_W'(1), hi: res.k_rng.hi};
                n_cnt     = r_cnt + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_iss       <= '0;
            r_pend      <= 1'b0;
            r_cnt       <= '0;
            r_w1_en     <= 1'b0;
            r_w2_en     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= issue;
            if (issue) begin
                r_pidx <= r_iss[IDX_W-1:0];
                r_iss  <= r_iss + CNT_W'(1);
            end
            if (accept) begin
                r_op  <= i_req_type;
                r_val <= i_value;
                r_iss <= '0;
            end
            if (r_state == S_DECIDE) begin
                r_w1_en   <= n_w1_en;
                r_w2_en   <= n_w2_en;
                r_w1_addr <= n_w1_addr;
                r_w2_addr <= n_w2_addr;
                r_w1_data <= n_w1_data;
                r_w2_data <= n_w2_data;
                r_full    <= n_full;
                r_cnt     <= n_cnt;
            end
            if ((r_state == S_RESP) && out_free) begin
                r_out_valid   <= 1'b1;
                r_out_present <= res.found_k;
                r_out_full    <= r_full;
                r_out_cnt     <= r_cnt;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // port drive
    always_comb begin
        o_stall       = (r_state != S_IDLE);
        o_valid       = r_out_valid;
        o_was_present = r_out_present;
        o_table_full  = r_out_full;
        o_range_count = r_out_cnt;
    end

    `SIS_ASSERT(a_cnt_bound, r_cnt <= CNT_W'(MAX_RANGES), "range count above capacity")
    `SIS_IMPLY(a_wr_phase, ram_wr_en, (r_state == S_WR1) || (r_state == S_WR2), "ram write outside write-back")
    `SIS_IMPLY(a_full_at_max, r_out_valid && r_out_full, r_out_cnt == CNT_W'(MAX_RANGES), "full flagged below capacity")
    `SIS_IMPLY(a_read_in_scan, r_pend, $past(r_state) == S_SCAN, "read data outside scan")
endmodule
`default_nettype wire

// ===== test/sorted_interval_set_tb.sv =====
// self-checking testbench for the sorted interval set
`default_nettype none
module sorted_interval_set_tb;
    import sis_pkg::*;

    typedef struct packed {
        logic             was_present;
        logic             table_full;
        logic [CNT_W-1:0] range_count;
    } t_answer;

    typedef struct {
        logic [1:0]       op;
        logic [VAL_W-1:0] value;
        logic             typed;
        t_answer          answer;
    } t_row;

    localparam logic [VAL_W-1:0] TOP = '1;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_valid = 1'b0;
    logic             o_stall;
    logic [1:0]       i_req_type = '0;
    logic [VAL_W-1:0] i_value = '0;
    logic             o_valid;
    logic             i_stall = 1'b0;
    logic             o_was_present;
    logic             o_table_full;
    logic [CNT_W-1:0] o_range_count;

    sorted_interval_set u_dut (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // model of the set: sorted disjoint, non-adjacent ranges
    logic [VAL_W-1:0] set_lo [MAX_RANGES+1];
    logic [VAL_W-1:0] set_hi [MAX_RANGES+1];
    int               set_n = 0;
    t_answer          answers_due [$];
    t_answer          typed_answers [$];
    logic             typed_flags [$];
    int               mismatches = 0;
    bit               calm = 1'b0;

    function automatic void shift_up(int pos);
        for (int j = set_n; j > pos; j--) begin
            set_lo[j] = set_lo[j-1];
            set_hi[j] = set_hi[j-1];
        end
        set_n++;
    endfunction

    function automatic void shift_down(int pos);
        for (int j = pos; j + 1 < set_n; j++) begin
            set_lo[j] = set_lo[j+1];
            set_hi[j] = set_hi[j+1];
        end
        set_n--;
    endfunction

    function automatic t_answer apply_request(logic [1:0] op, logic [VAL_W-1:0] v);
        int      pos = 0;
        bit      present, left, right;
        t_answer a;
        while (pos < set_n && set_lo[pos] <= v) pos++;
        present = pos > 0 && set_hi[pos-1] >= v;
        a.table_full = 1'b0;
        if (op == OP_INSERT && !present) begin
            left  = pos > 0 && set_hi[pos-1] != TOP && set_hi[pos-1] + 1 == v;
            right = pos < set_n && set_lo[pos] != 0 && set_lo[pos] - 1 == v;
            if (left && right) begin
                set_hi[pos-1] = set_hi[pos];
                shift_down(pos);
            end else if (left) set_hi[pos-1] = v;
            else if (right) set_lo[pos] = v;
            else if (set_n >= MAX_RANGES) a.table_full = 1'b1;
            else begin
                shift_up(pos);
                set_lo[pos] = v;
                set_hi[pos] = v;
            end
        end else if (op == OP_REMOVE && present) begin
            int k = pos - 1;
            if (set_lo[k] == set_hi[k]) shift_down(k);
            else if (v == set_lo[k]) set_lo[k] = v + 1;
            else if (v == set_hi[k]) set_hi[k] = v - 1;
            else if (set_n >= MAX_RANGES) a.table_full = 1'b1;
            else begin
                shift_up(k + 1);
                set_lo[k+1] = v + 1;
                set_hi[k+1] = set_hi[k];
                set_hi[k] = v - 1;
            end
        end
        a.was_present = present;
        a.range_count = set_n[CNT_W-1:0];
        return a;
    endfunction

    // valid stays high into the next word; idle gaps drop it
    task automatic send_word(logic [1:0] op, logic [VAL_W-1:0] v, bit typed, t_answer ta);
        t_answer a;
        while (!calm && $urandom_range(99) < 8) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_req_type <= op;
        i_value    <= v;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        a = apply_request(op, v);
        answers_due.push_back(a);
        typed_answers.push_back(ta);
        typed_flags.push_back(typed);
    endtask

    // receiver side: random stall, compare each accepted word
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                t_answer got, want, ta;
                bit      tf;
                got = '{o_was_present, o_table_full, o_range_count};
                if (answers_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result word %p", got);
                end else begin
                    want = answers_due.pop_front();
                    ta = typed_answers.pop_front();
                    tf = typed_flags.pop_front();
                    if (got !== want || (tf && got !== ta)) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p typed %p, got %p",
                                     want, ta, got);
                    end
                end
            end
            i_stall <= !calm && $urandom_range(99) < 8;
        end
    end

    initial begin
        #20000000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        t_row rows [$];
        rows = '{
            '{OP_QUERY,  32'd0, 1'b1, '{1'b0, 1'b0, 7'd0}},
            '{OP_REMOVE, 32'd5, 1'b1, '{1'b0, 1'b0, 7'd0}},
            '{OP_INSERT, 32'd0, 1'b1, '{1'b0, 1'b0, 7'd1}},
            '{OP_INSERT, TOP,   1'b1, '{1'b0, 1'b0, 7'd2}},
            '{OP_INSERT, TOP,   1'b1, '{1'b1, 1'b0, 7'd2}},
            '{OP_INSERT, TOP-1, 1'b0, '0},
            '{OP_INSERT, 32'd1, 1'b0, '0},
            '{OP_INSERT, 32'd3, 1'b0, '0},
            '{OP_INSERT, 32'd2, 1'b0, '0},
            '{OP_INSERT, 32'd10, 1'b0, '0},
            '{OP_INSERT, 32'd9, 1'b0, '0},
            '{OP_REMOVE, 32'd2, 1'b0, '0},
            '{OP_REMOVE, 32'd0, 1'b0, '0},
            '{OP_REMOVE, 32'd3, 1'b0, '0},
            '{OP_REMOVE, 32'd10, 1'b0, '0},
            '{OP_REMOVE, 32'd9, 1'b0, '0},
            '{2'd3,      TOP,   1'b1, '{1'b1, 1'b0, 7'd2}},
            '{OP_QUERY,  32'h8000_0000, 1'b0, '0},
            '{OP_REMOVE, TOP,   1'b0, '0},
            '{OP_REMOVE, TOP-1, 1'b0, '0},
            '{OP_QUERY,  TOP,   1'b0, '0}
        };
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (rows[r]) send_word(rows[r].op, rows[r].value, rows[r].typed, rows[r].answer);
        // fill the table with singletons, then hit the full cases
        for (int s = 0; s < MAX_RANGES + 2; s++)
            send_word(OP_INSERT, 32'h100 + 4 * s, 1'b0, '0);
        send_word(OP_INSERT, 32'h100 + 4 * 3 + 2, 1'b0, '0);
        send_word(OP_INSERT, 32'h100 + 4 * 5 + 1, 1'b0, '0);
        send_word(OP_INSERT, 32'h100 + 4 * 5 + 2, 1'b0, '0);
        send_word(OP_REMOVE, 32'h100 + 4 * 5 + 1, 1'b0, '0);
        for (int n = 0; n < 1400; n++) begin
            logic [1:0]       op;
            logic [VAL_W-1:0] v;
            calm = n >= 500 && n < 700;
            op = $urandom_range(99) < 3 ? 2'd3 : 2'($urandom_range(2));
            case ($urandom_range(9))
                0:       v = $urandom;
                1:       v = $urandom_range(1) ? TOP - $urandom_range(20) : $urandom_range(20);
                default: v = 32'h100 + $urandom_range(n < 900 ? 120 : 400);
            endcase
            // periodically drain the set so it does not stay pinned full
            if (n % 400 > 330 && set_n > 0) begin
                op = OP_REMOVE;
                v = set_lo[$urandom_range(set_n - 1)];
            end
            send_word(op, v, 1'b0, '0);
        end
        i_valid <= 1'b0;
        calm = 1'b0;
        while (answers_due.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (mismatches == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end
endmodule
`default_nettype wire

// ===== sim.f =====
+incdir+design
design/sis_pkg.sv
design/sis_ram.sv
design/sis_scan.sv
design/sorted_interval_set.sv
test/sorted_interval_set_tb.sv
